[src/rcp_pkg.sv]
// Shared constants and the CORDIC arctangent table for the rose curve point generator.
`timescale 1ns / 1ps

package rcp_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // CORDIC datapath width: Q2.30 values plus headroom for gain and sign
  localparam int CW = 34;

  localparam int AMP_W   = 15;
  localparam int PETAL_W = 8;
  localparam int ROT_W   = 16;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PETAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 2'd2;

  localparam logic [AMP_W-1:0]   AMP_RESET   = 15'd3840;
  localparam logic [PETAL_W-1:0] PETAL_RESET = 8'd3;
  localparam logic [ROT_W-1:0]   ROT_RESET   = 16'd10923;

  // 1/K in Q2.30, preloaded so the rotated vector comes out unit length
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  // round(atan(2^-i) / (2*pi) * 2^32)
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[src/rose_curve_point.sv]
// Rose curve point generator: top level with phase setup, two CORDICs, scaling and output skid.
// Path to m_tvalid: S0, CORDIC fold, iterations, negate, amplitude product, radius, xy product, output register.
// Throughput: one word per cycle when not stalled; the two CORDICs run side by side, one iteration per stage.
// The pipeline stalls as a whole only when the output register and its skid word are both full.
// Reset (rst, synchronous): clears all valid bits and loads amplitude 15.0, petal factor 3,
// rotation one sixth of a turn.
`timescale 1ns / 1ps

module rose_curve_point #(
  parameter int ANGLE_BITS    = rcp_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = rcp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rcp_pkg::IN_W-1:0]         s_tdata,   // [15:0] angle
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [2*rcp_pkg::OUT_W-1:0]      m_tdata,   // [15:0] x_coord, [31:16] y_coord
  input  logic                             cfg_we,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW    = rcp_pkg::CW;
  localparam int AB    = ANGLE_BITS;
  localparam int PW    = AB + rcp_pkg::PETAL_W;
  localparam int AW    = CW + rcp_pkg::AMP_W + 1;
  localparam int MW    = 2 * CW;
  localparam int OUT_W = rcp_pkg::OUT_W;
  // S0, CORDIC fold + iterations, negate, amplitude product, radius, xy product
  localparam int NSTG  = CORDIC_STAGES + 6;

  // configuration registers
  logic [rcp_pkg::AMP_W-1:0]   amplitude;
  logic [rcp_pkg::PETAL_W-1:0] petal_factor;
  logic [AB-1:0]               rotation;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= rcp_pkg::AMP_RESET;
      petal_factor <= rcp_pkg::PETAL_RESET;
      rotation     <= AB'(rcp_pkg::ROT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        rcp_pkg::REG_AMPLITUDE: amplitude    <= cfg_data[rcp_pkg::AMP_W-1:0];
        rcp_pkg::REG_PETAL:     petal_factor <= cfg_data[rcp_pkg::PETAL_W-1:0];
        rcp_pkg::REG_ROTATION:  rotation     <= AB'(cfg_data[rcp_pkg::ROT_W-1:0]);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            en;
  logic [NSTG-1:0] vld;
  logic            skid_vld;

  assign en       = !skid_vld;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_tvalid};
    end
  end

  // S0: phase = n * (theta - rotation) mod one turn
  logic [AB-1:0] theta_in;
  logic [AB-1:0] diff;
  logic [PW-1:0] phase_full;
  logic [AB-1:0] phase_s0;
  logic [AB-1:0] theta_s0;

  always_comb begin
    theta_in   = AB'(s_tdata);
    diff       = theta_in - rotation;
    phase_full = PW'(diff) * PW'(petal_factor);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_s0 <= phase_full[AB-1:0];
      theta_s0 <= theta_in;
    end
  end

  logic [31:0] turn_phase;
  logic [31:0] turn_theta;

  assign turn_phase = 32'(phase_s0) << (32 - AB);
  assign turn_theta = 32'(theta_s0) << (32 - AB);

  logic signed [CW-1:0] cx_p, sy_p, cx_t, sy_t;
  logic                 neg_p, neg_t;

  rcp_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic_phase (
    .clk    (clk),
    .en     (en),
    .turn   (turn_phase),
    .x_out  (cx_p),
    .y_out  (sy_p),
    .neg_out(neg_p)
  );

  rcp_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic_theta (
    .clk    (clk),
    .en     (en),
    .turn   (turn_theta),
    .x_out  (cx_t),
    .y_out  (sy_t),
    .neg_out(neg_t)
  );

  // undo the half-turn fold, then scale
  logic signed [CW-1:0] sp_n, ct_n, st_n;
  logic signed [AW-1:0] rprod;
  logic signed [CW-1:0] ct_a, st_a;
  logic signed [CW-1:0] r_q;
  logic signed [CW-1:0] ct_r, st_r;
  logic signed [MW-1:0] px, py;

  always_ff @(posedge clk) begin
    if (en) begin
      sp_n  <= neg_p ? -sy_p : sy_p;
      ct_n  <= neg_t ? -cx_t : cx_t;
      st_n  <= neg_t ? -sy_t : sy_t;

      rprod <= $signed({1'b0, amplitude}) * sp_n;
      ct_a  <= ct_n;
      st_a  <= st_n;

      r_q   <= CW'((rprod + AW'(16384)) >>> 15);
      ct_r  <= ct_a;
      st_r  <= st_a;

      px    <= r_q * ct_r;
      py    <= r_q * st_r;
    end
  end

  function automatic logic [OUT_W-1:0] round_clamp(input logic signed [MW-1:0] p);
    logic signed [MW-1:0] v;
    v = (p + (MW'(1) <<< 44)) >>> 45;
    if (v > MW'(32767)) begin
      return 16'h7FFF;
    end else if (v < -MW'(32768)) begin
      return 16'h8000;
    end
    return v[OUT_W-1:0];
  endfunction

  logic [2*OUT_W-1:0] word_new;
  logic [2*OUT_W-1:0] skid_data;
  logic               produce;

  assign word_new = {round_clamp(py), round_clamp(px)};
  assign produce  = vld[NSTG-1] && en;

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (m_tready) begin
        m_tdata  <= skid_data;
        skid_vld <= 1'b0;
      end
    end else if (produce) begin
      if (!m_tvalid || m_tready) begin
        m_tdata  <= word_new;
        m_tvalid <= 1'b1;
      end else begin
        skid_data <= word_new;
        skid_vld  <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> m_tvalid)
    else $error("skid word held while output register empty");

  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && !skid_vld && vld[NSTG-1]) |=> skid_vld)
    else $error("finished word not captured in skid");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_vld && !m_tready) |=> (skid_vld && $stable(skid_data)))
    else $error("skid word lost while output stalled");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_vld |=> $stable(vld))
    else $error("pipeline moved while stalled");
`endif

endmodule

[src/rcp_cordic.sv]
// Pipelined rotation-mode CORDIC: one register stage for quadrant fold, one per iteration.
`timescale 1ns / 1ps

module rcp_cordic #(
  parameter int CORDIC_STAGES = rcp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [31:0]                   turn,
  output logic signed [rcp_pkg::CW-1:0] x_out,
  output logic signed [rcp_pkg::CW-1:0] y_out,
  output logic                          neg_out
);

  localparam int CW = rcp_pkg::CW;

  logic signed [CW-1:0] xs [0:CORDIC_STAGES];
  logic signed [CW-1:0] ys [0:CORDIC_STAGES];
  logic signed [CW-1:0] zs [0:CORDIC_STAGES];
  logic                 ng [0:CORDIC_STAGES];

  logic        fold;
  logic [31:0] turn_red;

  // second and third quadrants fold by a half turn; result is negated later
  always_comb begin
    fold     = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    turn_red = fold ? (turn ^ 32'h8000_0000) : turn;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= rcp_pkg::GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= CW'(signed'(turn_red));
      ng[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [CW-1:0] ATAN = CW'(rcp_pkg::atan_turn(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN;
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  assign x_out   = xs[CORDIC_STAGES];
  assign y_out   = ys[CORDIC_STAGES];
  assign neg_out = ng[CORDIC_STAGES];

endmodule

[test/rose_point_checker.sv]
// Channel monitor for the rose curve point generator: predicts each point and compares.
`timescale 1ns / 1ps

module rose_point_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [rcp_pkg::IN_W-1:0]         s_tdata,   // [15:0] angle
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [2*rcp_pkg::OUT_W-1:0]      m_tdata,   // [15:0] x_coord, [31:16] y_coord
  input  logic                             cfg_we,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               mismatches,
  output int                               pending_points
);

  // y_coord first so x_coord lands in the low half of the word
  typedef struct packed {
    logic signed [rcp_pkg::OUT_W-1:0] y_coord;
    logic signed [rcp_pkg::OUT_W-1:0] x_coord;
  } point_t;

  localparam longint UNIT_GAIN = 64'sd652032874;  // 1/K in Q2.30
  localparam int     STAGES    = 16;

  logic [rcp_pkg::AMP_W-1:0]   amplitude_q;
  logic [rcp_pkg::PETAL_W-1:0] petal_q;
  logic [rcp_pkg::ROT_W-1:0]   rotation_q;

  point_t expected_points[$];
  point_t want;
  point_t got;

  // atan(2^-i) in 32-bit turn units
  function automatic longint turn_atan(input int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      15: return 64'h0000517D;
      default: return 64'h0;
    endcase
  endfunction

  // cos/sin in Q2.30 of a 32-bit turn angle
  function automatic void unit_vector(input logic [31:0] turn, output longint cos_v,
                                      output longint sin_v);
    longint x;
    longint y;
    longint z;
    longint t;
    logic [31:0] u;
    logic flip;
    u = turn;
    // second and third quadrants: rotate by a half turn and negate afterwards
    flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
    if (flip) u = u - 32'h8000_0000;
    x = UNIT_GAIN;
    y = 0;
    z = $signed(u);
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        x = t;
        z = z - turn_atan(i);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        x = t;
        z = z + turn_atan(i);
      end
    end
    cos_v = flip ? -x : x;
    sin_v = flip ? -y : y;
  endfunction

  // radius (Q.23) times a Q2.30 factor, rounded to Q7.8 and clamped
  function automatic logic signed [rcp_pkg::OUT_W-1:0] scale_q78(input longint radius,
                                                                input longint factor);
    longint v;
    v = (radius * factor + 64'sd17592186044416) >>> 45;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[rcp_pkg::OUT_W-1:0];
  endfunction

  function automatic point_t rose_point(input logic [rcp_pkg::IN_W-1:0] theta);
    logic [15:0] offset;
    logic [15:0] phase;
    longint cos_p;
    longint sin_p;
    longint cos_t;
    longint sin_t;
    longint amp;
    longint radius;
    point_t p;
    offset = theta - rotation_q;
    phase = petal_q * offset;
    unit_vector({phase, 16'h0000}, cos_p, sin_p);
    unit_vector({theta, 16'h0000}, cos_t, sin_t);
    amp = amplitude_q;
    radius = (amp * sin_p + 64'sd16384) >>> 15;
    p.x_coord = scale_q78(radius, cos_t);
    p.y_coord = scale_q78(radius, sin_t);
    return p;
  endfunction

  task automatic report_field(input string field, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      amplitude_q = rcp_pkg::AMP_RESET;
      petal_q = rcp_pkg::PETAL_RESET;
      rotation_q = rcp_pkg::ROT_RESET;
      expected_points.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_points.push_back(rose_point(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word, x_coord %0d, y_coord %0d", $time,
                     got.x_coord, got.y_coord);
        end else begin
          want = expected_points.pop_front();
          if (got.x_coord !== want.x_coord) report_field("x_coord", want.x_coord, got.x_coord);
          if (got.y_coord !== want.y_coord) report_field("y_coord", want.y_coord, got.y_coord);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          rcp_pkg::REG_AMPLITUDE: amplitude_q = cfg_data[rcp_pkg::AMP_W-1:0];
          rcp_pkg::REG_PETAL:     petal_q = cfg_data[rcp_pkg::PETAL_W-1:0];
          rcp_pkg::REG_ROTATION:  rotation_q = cfg_data[rcp_pkg::ROT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_points = expected_points.size();
  end

endmodule

[test/tb_rose_curve_point.sv]
// Top-level testbench for the rose curve point generator: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_rose_curve_point;

  localparam int LATENCY     = rcp_pkg::CORDIC_STAGES_DEF + 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam logic [rcp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [rcp_pkg::IN_W-1:0]         s_tdata;   // [15:0] angle
  logic                             m_tvalid;
  logic                             m_tready;
  logic [2*rcp_pkg::OUT_W-1:0]      m_tdata;   // [15:0] x_coord, [31:16] y_coord
  logic                             cfg_we;
  logic [rcp_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [rcp_pkg::CFG_DATA_W-1:0]   cfg_data;

  int mismatches;
  int pending_points;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;

  // quadrant edges, their neighbors, octants, the default rotation, odd patterns
  logic [rcp_pkg::IN_W-1:0] corner_angles [18] = '{
    16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF,
    16'h4001, 16'h7FFF, 16'h8001, 16'hBFFF, 16'hC001, 16'h2000,
    16'h6000, 16'hA000, 16'hE000, 16'd10923, 16'h5555, 16'hAAAA
  };

  always #5 clk = ~clk;

  rose_curve_point dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rose_point_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending_points(pending_points)
  );

  // receiver: drops m_tready in random stall bursts
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_angle(input logic [rcp_pkg::IN_W-1:0] angle);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = angle;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [rcp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcp_pkg::CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
  endtask

  task automatic drain_points();
    s_tvalid = 1'b0;
    while (pending_points != 0) @(negedge clk);
  endtask

  // idle long enough that no word is still in flight
  task automatic settle();
    drain_points();
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // mostly uniform, a quarter of the time close to a quadrant boundary
  function automatic logic [rcp_pkg::IN_W-1:0] pick_angle();
    if ($urandom_range(0, 3) == 0)
      return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 8) - 4);
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // reset settings
    foreach (corner_angles[i]) send_angle(corner_angles[i]);
    settle();

    // full amplitude from an over-wide write, zero petal factor from masking
    write_reg(rcp_pkg::REG_AMPLITUDE, 16'hFFFF);
    write_reg(rcp_pkg::REG_PETAL, 16'h0100);
    write_reg(rcp_pkg::REG_ROTATION, 16'h0000);
    write_reg(REG_UNUSED, 16'h1234);
    cfg_we = 1'b0;
    send_angle(16'h0000);
    send_angle(16'h2000);
    send_angle(16'h6000);
    send_angle(16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      tx_gaps = (p != 2) && (p < 6);
      rx_stalls = (p != 1) && (p < 6);
      case (p)
        0: begin
          write_reg(rcp_pkg::REG_AMPLITUDE, 16'hFFFF);
          write_reg(rcp_pkg::REG_PETAL, 16'h00FF);
          write_reg(rcp_pkg::REG_ROTATION, 16'hFFFF);
        end
        1: begin
          write_reg(rcp_pkg::REG_AMPLITUDE, 16'h0000);
          write_reg(rcp_pkg::REG_PETAL, 16'h0001);
          write_reg(rcp_pkg::REG_ROTATION, 16'h0000);
        end
        2: begin
          write_reg(rcp_pkg::REG_AMPLITUDE, 16'h7FFF);
          write_reg(rcp_pkg::REG_PETAL, 16'h0001);
          write_reg(rcp_pkg::REG_ROTATION, 16'($urandom_range(0, 65535)));
        end
        default: begin
          write_reg(rcp_pkg::REG_AMPLITUDE, 16'($urandom_range(0, 65535)));
          write_reg(rcp_pkg::REG_PETAL,
                    ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, 16)));
          write_reg(rcp_pkg::REG_ROTATION, 16'($urandom_range(0, 65535)));
        end
      endcase
      write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      cfg_we = 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) drain_points();
        send_angle(pick_angle());
      end
    end

    settle();
    if (mismatches == 0 && pending_points == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
